FILE: hdl/npcs_pkg.sv
// ----------------------------------------------------------------------------
// npcs_pkg: shared constants and types for the nearest palette color search
// Holds the palette size, field widths and the cell-to-cell token struct.
// ----------------------------------------------------------------------------
package npcs_pkg;

  localparam int unsigned PaletteEntries = 256;
  localparam int unsigned IdxW = 8;
  localparam int unsigned ChW = 8;
  localparam int unsigned DistW = 18;
  localparam logic [DistW-1:0] DistBound = DistW'(255 * 255 * 3);

  localparam logic ActLoad = 1'b0;
  localparam logic ActQuery = 1'b1;

  typedef struct packed {
    logic [ChW-1:0] red;
    logic [ChW-1:0] green;
    logic [ChW-1:0] blue;
  } rgb_t;

  // Query token that travels down the cell row
  typedef struct packed {
    logic             vld;
    rgb_t             color;
    logic [DistW-1:0] best_dist;
    logic [IdxW-1:0]  best_idx;
  } token_t;

endpackage

FILE: hdl/npcs_cell.sv
// ----------------------------------------------------------------------------
// npcs_cell: one palette entry and its distance compare stage
// Holds one entry, compares the passing query against it, hands the token on.
// ----------------------------------------------------------------------------
module npcs_cell (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [npcs_pkg::IdxW-1:0]        cell_idx_i,
  input  logic                             wr_en_i,
  input  npcs_pkg::rgb_t                   wr_color_i,
  input  npcs_pkg::token_t                 tok_i,
  output npcs_pkg::token_t                 tok_o
);

  npcs_pkg::rgb_t   entry_q;
  npcs_pkg::token_t tok_q;
  logic [npcs_pkg::ChW-1:0]   dr, dg, db;
  logic [npcs_pkg::DistW-1:0] sq_sum;
  npcs_pkg::token_t tok_d;

  always_comb begin
    dr = (entry_q.red >= tok_i.color.red) ? entry_q.red - tok_i.color.red
                                          : tok_i.color.red - entry_q.red;
    dg = (entry_q.green >= tok_i.color.green) ? entry_q.green - tok_i.color.green
                                              : tok_i.color.green - entry_q.green;
    db = (entry_q.blue >= tok_i.color.blue) ? entry_q.blue - tok_i.color.blue
                                            : tok_i.color.blue - entry_q.blue;
    sq_sum = npcs_pkg::DistW'({{npcs_pkg::ChW{1'b0}}, dr} * {{npcs_pkg::ChW{1'b0}}, dr})
           + npcs_pkg::DistW'({{npcs_pkg::ChW{1'b0}}, dg} * {{npcs_pkg::ChW{1'b0}}, dg})
           + npcs_pkg::DistW'({{npcs_pkg::ChW{1'b0}}, db} * {{npcs_pkg::ChW{1'b0}}, db});
    tok_d = tok_i;
    // strict less keeps the lowest index on ties
    if (sq_sum < tok_i.best_dist) begin
      tok_d.best_dist = sq_sum;
      tok_d.best_idx  = cell_idx_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
      tok_q   <= '0;
    end else begin
      if (wr_en_i) begin
        entry_q <= wr_color_i;
      end
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

FILE: hdl/nearest_palette_color_search.sv
// ----------------------------------------------------------------------------
// nearest_palette_color_search: nearest RGB palette entry by squared distance
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_stall_o) carries load and query transactions.
// A load writes one palette entry in the cycle it is accepted; no result.
// A query enters a row of 256 cells, one palette entry per cell, and moves one
// cell per cycle, keeping the best distance and lowest index found so far.
// The last cell feeds the output register directly: a query passes through
// the 256 cell registers, then the output register drives out_valid_o and
// out_nearest_idx_o. One query is in flight at a time, so a new query is
// taken only after the last has left the cell row; a load raises no stall.
// in_stall_o stays high from a query's acceptance until its result has moved
// into the output register, and also while a result waits there stalled.
// With no query in flight, a new transaction is taken once the output register
// is empty or is being emptied in the same cycle; a result is never overwritten.
// Reset clears the whole palette to zero and empties the row and output.
// ----------------------------------------------------------------------------
module nearest_palette_color_search (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       in_action_i,
  input  logic [7:0] in_entry_index_i,
  input  logic [7:0] in_red_i,
  input  logic [7:0] in_green_i,
  input  logic [7:0] in_blue_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_nearest_idx_o
);

  localparam int unsigned N = npcs_pkg::PaletteEntries;

  npcs_pkg::token_t tok [N+1];
  npcs_pkg::token_t inj;
  npcs_pkg::rgb_t   wr_color;
  logic             busy_q, busy_d;
  logic             out_valid_q;
  logic [7:0]       out_idx_q;
  logic             acc, done, out_free;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = busy_q || !out_free;
  assign acc        = in_valid_i && !in_stall_o;
  assign done       = tok[N].vld;

  assign wr_color = '{red: in_red_i, green: in_green_i, blue: in_blue_i};

  always_comb begin
    inj.vld       = acc && (in_action_i == npcs_pkg::ActQuery);
    inj.color     = wr_color;
    inj.best_dist = npcs_pkg::DistBound;
    inj.best_idx  = '0;
  end
  assign tok[0] = inj;

  for (genvar g = 0; g < N; g++) begin : g_cell
    npcs_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_idx_i (npcs_pkg::IdxW'(g)),
      .wr_en_i    (acc && (in_action_i == npcs_pkg::ActLoad)
                   && (in_entry_index_i == npcs_pkg::IdxW'(g))),
      .wr_color_i (wr_color),
      .tok_i      (tok[g]),
      .tok_o      (tok[g+1])
    );
  end

  // The row never stalls; busy covers the query's trip and the
  // output register must be free before a query may launch.
  always_comb begin
    busy_d = busy_q;
    if (inj.vld) begin
      busy_d = 1'b1;
    end else if (done) begin
      busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      if (done) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      out_idx_q <= tok[N].best_idx;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_nearest_idx_o = out_idx_q;

endmodule

FILE: hdl/npcs_checker.sv
// ----------------------------------------------------------------------------
// npcs_checker: port-level checks for the nearest palette color search
// Watches the handshakes and the stalled result hold at the top level's ports.
// ----------------------------------------------------------------------------
module npcs_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       in_action_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] out_nearest_idx_o
);

  // a query transaction closes the input side
  a_query_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && in_action_i) |=> in_stall_o)
    else $error("query did not raise stall");

  // a load transaction leaves the input open
  a_load_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && !in_action_i) |=> !in_stall_o)
    else $error("load raised stall");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_nearest_idx_o)))
    else $error("stalled result changed");

endmodule

bind nearest_palette_color_search npcs_checker u_npcs_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_valid_i),
  .in_stall_o        (in_stall_o),
  .in_action_i       (in_action_i),
  .out_valid_o       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .out_nearest_idx_o (out_nearest_idx_o)
);

FILE: tb/tb_nearest_palette_color_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_nearest_palette_color_search: self-checking bench for the palette search
// Runs a table of directed loads and queries, then random traffic. Each query
// result is compared with a local nearest-color predictor, and both handshake
// sides idle and stall at random, including one long output hold-off.
// ----------------------------------------------------------------------------
module tb_nearest_palette_color_search;

  localparam int NumRandom = 1830;
  localparam int HoldCycles = 3000;
  localparam int NoExp = -1;

  typedef struct {
    logic       action;
    logic [7:0] entry;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    int         want;
  } txn_t;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic       in_action_i;
  logic [7:0] in_entry_index_i;
  logic [7:0] in_red_i;
  logic [7:0] in_green_i;
  logic [7:0] in_blue_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [7:0] out_nearest_idx_o;

  logic [23:0] palette_mirror [npcs_pkg::PaletteEntries];
  logic [7:0]  index_queue [$];
  int          errors;
  int          results_seen;
  int          queries_sent;
  int          loads_sent;
  bit          quiet;
  bit          hold_req;

  nearest_palette_color_search i_dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("FAIL nearest_palette_color_search");
    $finish;
  end

  function automatic logic [7:0] nearest_index(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    int best_dist;
    int best_idx;
    int dr, dg, db, sq_sum;
    best_dist = 255 * 255 * 3;
    best_idx = 0;
    for (int i = 0; i < npcs_pkg::PaletteEntries; i++) begin
      dr = int'(palette_mirror[i][23:16]) - int'(r);
      dg = int'(palette_mirror[i][15:8]) - int'(g);
      db = int'(palette_mirror[i][7:0]) - int'(b);
      sq_sum = dr * dr + dg * dg + db * db;
      if (sq_sum < best_dist) begin
        best_dist = sq_sum;
        best_idx = i;
      end
    end
    return best_idx[7:0];
  endfunction

  task automatic report_mismatch(string what);
    $display("%0t mismatch: %s", $realtime, what);
    errors++;
  endtask

  // Update the mirror and queue the expected index for an accepted transaction
  task automatic track_accepted(txn_t t);
    logic [7:0] pred;
    if (t.action == npcs_pkg::ActLoad) begin
      if (t.entry < npcs_pkg::PaletteEntries) palette_mirror[t.entry] = {t.red, t.green, t.blue};
      loads_sent++;
    end else begin
      pred = nearest_index(t.red, t.green, t.blue);
      if (t.want != NoExp && pred != t.want[7:0])
        report_mismatch($sformatf("predictor %0d vs table %0d", pred, t.want));
      index_queue.push_back(t.want == NoExp ? pred : t.want[7:0]);
      queries_sent++;
    end
  endtask

  task automatic send_txn(txn_t t);
    if (!quiet && $urandom_range(99) < 36) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_action_i <= t.action;
    in_entry_index_i <= t.entry;
    in_red_i <= t.red;
    in_green_i <= t.green;
    in_blue_i <= t.blue;
    do @(posedge clk_i); while (in_stall_o);
    track_accepted(t);
  endtask

  // Output side: check results and stall at random or during the hold-off
  initial begin
    int hold_left;
    hold_left = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (index_queue.size() == 0) begin
          report_mismatch($sformatf("unexpected result %0d", out_nearest_idx_o));
        end else begin
          logic [7:0] exp_idx;
          exp_idx = index_queue.pop_front();
          if (out_nearest_idx_o !== exp_idx)
            report_mismatch($sformatf("nearest index %0d, expected %0d",
                                      out_nearest_idx_o, exp_idx));
        end
      end
      if (hold_req && hold_left == 0) begin
        hold_req = 1'b0;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= !quiet && ($urandom_range(99) < 36);
      end
    end
  end

  initial begin
    txn_t dir [$];
    txn_t t;
    int drain;
    errors = 0;
    results_seen = 0;
    queries_sent = 0;
    loads_sent = 0;
    quiet = 1'b0;
    hold_req = 1'b0;
    foreach (palette_mirror[i]) palette_mirror[i] = '0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_action_i = npcs_pkg::ActLoad;
    in_entry_index_i = '0;
    in_red_i = '0;
    in_green_i = '0;
    in_blue_i = '0;
    out_stall_i = 1'b0;

    // action, entry, red, green, blue, expected index
    dir = '{
      '{npcs_pkg::ActQuery, 8'hAA, 8'd0,   8'd0,   8'd0,   0},      // cleared palette
      '{npcs_pkg::ActQuery, 8'h55, 8'd255, 8'd255, 8'd255, 0},      // all at the bound
      '{npcs_pkg::ActLoad,  8'd255, 8'd255, 8'd255, 8'd255, NoExp},
      '{npcs_pkg::ActQuery, 8'd0,  8'd255, 8'd255, 8'd255, 255},    // top entry match
      '{npcs_pkg::ActQuery, 8'hFF, 8'd200, 8'd200, 8'd200, 255},
      '{npcs_pkg::ActLoad,  8'd10, 8'd1,   8'd2,   8'd3,   NoExp},
      '{npcs_pkg::ActLoad,  8'd20, 8'd1,   8'd2,   8'd3,   NoExp},
      '{npcs_pkg::ActQuery, 8'd0,  8'd1,   8'd2,   8'd3,   10},     // first match wins
      '{npcs_pkg::ActQuery, 8'd0,  8'd0,   8'd0,   8'd0,   0},
      '{npcs_pkg::ActLoad,  8'd0,  8'd255, 8'd0,   8'd0,   NoExp},
      '{npcs_pkg::ActLoad,  8'd1,  8'd0,   8'd255, 8'd0,   NoExp},
      '{npcs_pkg::ActLoad,  8'd2,  8'd0,   8'd0,   8'd255, NoExp},
      '{npcs_pkg::ActQuery, 8'd0,  8'd250, 8'd0,   8'd0,   0},
      '{npcs_pkg::ActQuery, 8'd0,  8'd0,   8'd250, 8'd0,   1},
      '{npcs_pkg::ActQuery, 8'd0,  8'd0,   8'd0,   8'd250, 2},
      '{npcs_pkg::ActQuery, 8'd0,  8'd0,   8'd0,   8'd0,   3},      // lowest zero entry
      '{npcs_pkg::ActLoad,  8'd30, 8'd11,  8'd11,  8'd11,  NoExp},
      '{npcs_pkg::ActLoad,  8'd31, 8'd9,   8'd9,   8'd9,   NoExp},
      '{npcs_pkg::ActQuery, 8'd0,  8'd10,  8'd10,  8'd10,  NoExp},  // equal-distance tie
      '{npcs_pkg::ActQuery, 8'd0,  8'd128, 8'd64,  8'd32,  NoExp}
    };

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir[i]) send_txn(dir[i]);

    for (int n = 0; n < NumRandom; n++) begin
      quiet = (n >= 600 && n < 900);
      if (n == 300) hold_req = 1'b1;
      t.want = NoExp;
      t.action = ($urandom_range(99) < 40) ? npcs_pkg::ActQuery : npcs_pkg::ActLoad;
      t.entry = 8'($urandom_range(255));
      if ($urandom_range(9) == 0) begin
        // extreme channel values
        t.red = $urandom_range(1) ? 8'hFF : 8'h00;
        t.green = $urandom_range(1) ? 8'hFF : 8'h00;
        t.blue = $urandom_range(1) ? 8'hFF : 8'h00;
      end else if (t.action == npcs_pkg::ActQuery && $urandom_range(2) == 0) begin
        // land on or near a stored color to hit exact matches and ties
        logic [23:0] c;
        c = palette_mirror[$urandom_range(255)];
        t.red = c[23:16] + 8'($urandom_range(2)) - 8'd1;
        t.green = c[15:8] + 8'($urandom_range(2)) - 8'd1;
        t.blue = c[7:0];
      end else begin
        t.red = 8'($urandom_range(255));
        t.green = 8'($urandom_range(255));
        t.blue = 8'($urandom_range(255));
      end
      send_txn(t);
    end
    in_valid_i <= 1'b0;

    while (index_queue.size() != 0) @(posedge clk_i);
    drain = 0;
    while (drain < 300) begin
      @(posedge clk_i);
      drain++;
    end

    $display("Covered %0d loads and %0d queries, %0d results checked,",
             loads_sent, queries_sent, results_seen);
    $display("with random idling on both sides and a %0d-cycle output hold-off.", HoldCycles);
    if (errors == 0) begin
      $display("PASS nearest_palette_color_search");
    end else begin
      $display("FAIL nearest_palette_color_search");
    end
    $finish;
  end

endmodule
